// File: hw/rtl/ptp_pkg.sv
package ptp_pkg;

  // Field widths
  localparam int INDEX_BITS  = 10;
  localparam int TASK_BITS   = 8;
  localparam int MISS_BITS   = 32;
  localparam int PRED_BITS   = 9;
  localparam int WEIGHT_BITS = 5;
  localparam int CMD_BITS    = 2;
  localparam int DIR_BITS    = 2;

  // Table depths
  localparam int W_DEPTH = 1 << INDEX_BITS;
  localparam int A_DEPTH = 1 << TASK_BITS;

  // Clear sweep covers the deeper table; the shallower one is rewritten with zero
  localparam int CLR_BITS = (INDEX_BITS > TASK_BITS) ? INDEX_BITS : TASK_BITS;

  // Saturation limits
  localparam int WEIGHT_MIN = -16;
  localparam int WEIGHT_MAX = 15;
  localparam int SUM_MIN    = -256;
  localparam int SUM_MAX    = 240;

  // APB
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_START  = 2'd1,
    CMD_UPDATE = 2'd2
  } cmd_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: hw/rtl/perceptron_task_predictor.sv
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   cmd, feature_index, task_key, miss_count,
//                                          last_feature
// out_      result     out_valid/out_stall prediction (signed, -256..240)
// cfg (APB) write/read psel/penable/pready rank_xor at byte address 0
//
// Steps: each request reads the weight and average memories in idle (registered
//   read port), then sums, emits or writes back in execute before the next is taken.
// Reset: a clearing pass over every address of the deeper table zeroes both
//   memories; no request is taken meanwhile, APB writes are.
// Stalls: a finished prediction waits in the output register; new requests are
//   still taken, and only a check that emits holds in execute while it is full and stalled.
module perceptron_task_predictor (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [ptp_pkg::CMD_BITS-1:0]            in_cmd,
  input  logic [ptp_pkg::INDEX_BITS-1:0]          in_feature_index,
  input  logic [ptp_pkg::TASK_BITS-1:0]           in_task_key,
  input  logic [ptp_pkg::MISS_BITS-1:0]           in_miss_count,
  input  logic                                    in_last_feature,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ptp_pkg::PRED_BITS-1:0]    out_prediction,
  // APB configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [ptp_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  logic [ptp_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [ptp_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);

  localparam logic [ptp_pkg::CLR_BITS-1:0] CLR_LAST = {ptp_pkg::CLR_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration: single register rank_xor at word 0
  // ---------------------------------------------------------------------------
  logic [ptp_pkg::INDEX_BITS-1:0] rank_xor_r;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_xor_r <= '0;
    end else if (cfg_wr) begin
      rank_xor_r <= pwdata[ptp_pkg::INDEX_BITS-1:0];
    end
  end

  assign prdata = paddr[2] ? '0
                : {{(ptp_pkg::APB_DATA_BITS-ptp_pkg::INDEX_BITS){1'b0}}, rank_xor_r};

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  ptp_pkg::state_t                  state_r, state_nxt;
  logic [ptp_pkg::CLR_BITS-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic signed [ptp_pkg::PRED_BITS-1:0] sum_r, sum_nxt;
  ptp_pkg::dir_t                    dir_r, dir_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [ptp_pkg::PRED_BITS-1:0] out_pred_r, out_pred_nxt;

  // Request held for the execute cycle
  ptp_pkg::cmd_t                    cmd_r;
  logic [ptp_pkg::INDEX_BITS-1:0]   slot_r;
  logic [ptp_pkg::TASK_BITS-1:0]    key_r;
  logic [ptp_pkg::MISS_BITS-1:0]    miss_r;
  logic                             last_r;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Memories: weights and per-task miss averages
  // ---------------------------------------------------------------------------
  logic                               w_we, a_we, rd_en;
  logic [ptp_pkg::INDEX_BITS-1:0]     w_waddr, w_raddr;
  logic [ptp_pkg::TASK_BITS-1:0]      a_waddr;
  logic [ptp_pkg::WEIGHT_BITS-1:0]    w_wdata, w_rdata;
  logic [ptp_pkg::MISS_BITS-1:0]      a_wdata, a_rdata;

  assign w_raddr = in_feature_index ^ rank_xor_r;

  ptp_ram #(
    .WIDTH (ptp_pkg::WEIGHT_BITS),
    .DEPTH (ptp_pkg::W_DEPTH)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_en   (rd_en),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  ptp_ram #(
    .WIDTH (ptp_pkg::MISS_BITS),
    .DEPTH (ptp_pkg::A_DEPTH)
  ) u_avg_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (a_wdata),
    .rd_en   (rd_en),
    .rd_addr (in_task_key),
    .rd_data (a_rdata)
  );

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  // check: running sum, saturated after each add
  logic signed [ptp_pkg::PRED_BITS:0]   sum_ext;
  logic signed [ptp_pkg::PRED_BITS-1:0] sum_sat;
  logic signed [ptp_pkg::WEIGHT_BITS-1:0] w_s;

  assign w_s     = w_rdata;
  assign sum_ext = {sum_r[ptp_pkg::PRED_BITS-1], sum_r}
                 + {{(ptp_pkg::PRED_BITS+1-ptp_pkg::WEIGHT_BITS){w_s[ptp_pkg::WEIGHT_BITS-1]}},
                    w_s};

  always_comb begin
    if (sum_ext < (ptp_pkg::PRED_BITS+1)'(ptp_pkg::SUM_MIN)) begin
      sum_sat = ptp_pkg::PRED_BITS'(ptp_pkg::SUM_MIN);
    end else if (sum_ext > (ptp_pkg::PRED_BITS+1)'(ptp_pkg::SUM_MAX)) begin
      sum_sat = ptp_pkg::PRED_BITS'(ptp_pkg::SUM_MAX);
    end else begin
      sum_sat = sum_ext[ptp_pkg::PRED_BITS-1:0];
    end
  end

  // update feature: one step toward the latched direction, clamped
  logic [ptp_pkg::WEIGHT_BITS-1:0] w_step;

  always_comb begin
    w_step = w_rdata;
    if (dir_r == ptp_pkg::DIR_DOWN
        && w_s != ptp_pkg::WEIGHT_BITS'(ptp_pkg::WEIGHT_MIN)) begin
      w_step = w_rdata - ptp_pkg::WEIGHT_BITS'(1);
    end else if (dir_r == ptp_pkg::DIR_UP
                 && w_s != ptp_pkg::WEIGHT_BITS'(ptp_pkg::WEIGHT_MAX)) begin
      w_step = w_rdata + ptp_pkg::WEIGHT_BITS'(1);
    end
  end

  // update start: average with a carry bit so the add cannot wrap
  logic [ptp_pkg::MISS_BITS:0]   avg_sum;
  logic [ptp_pkg::MISS_BITS-1:0] avg_new;
  logic                          avg_empty;
  ptp_pkg::dir_t                 dir_new;

  assign avg_sum   = {1'b0, a_rdata} + {1'b0, miss_r};
  assign avg_empty = (a_rdata == '0);
  assign avg_new   = avg_empty ? miss_r : avg_sum[ptp_pkg::MISS_BITS:1];

  always_comb begin
    if (avg_empty || miss_r == a_rdata) begin
      dir_new = ptp_pkg::DIR_NONE;
    end else if (miss_r > a_rdata) begin
      dir_new = ptp_pkg::DIR_DOWN;  // more misses: weaker vote
    end else begin
      dir_new = ptp_pkg::DIR_UP;
    end
  end

  // A check that emits must wait while the output register is full and stalled
  logic emit_wait;
  assign emit_wait = (cmd_r == ptp_pkg::CMD_CHECK) && last_r && out_valid_r && out_stall;

  // ---------------------------------------------------------------------------
  // FSM: clear sweep, idle (take request + issue reads), execute (sum, emit or write back)
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    sum_nxt       = sum_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pred_nxt  = out_pred_r;
    in_stall      = 1'b1;
    rd_en         = 1'b0;
    w_we          = 1'b0;
    w_waddr       = slot_r;
    w_wdata       = w_step;
    a_we          = 1'b0;
    a_waddr       = key_r;
    a_wdata       = avg_new;

    unique case (state_r)
      ptp_pkg::ST_CLEAR: begin
        w_we        = 1'b1;
        w_waddr     = clr_cnt_r[ptp_pkg::INDEX_BITS-1:0];
        w_wdata     = '0;
        a_we        = 1'b1;
        a_waddr     = clr_cnt_r[ptp_pkg::TASK_BITS-1:0];
        a_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + ptp_pkg::CLR_BITS'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ptp_pkg::ST_IDLE;
        end
      end
      ptp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = ptp_pkg::ST_EXEC;
        end
      end
      ptp_pkg::ST_EXEC: begin
        if (!emit_wait) begin
          state_nxt = ptp_pkg::ST_IDLE;
          case (cmd_r)
            ptp_pkg::CMD_CHECK: begin
              if (last_r) begin
                out_valid_nxt = 1'b1;
                out_pred_nxt  = sum_sat;
                sum_nxt       = '0;
              end else begin
                sum_nxt = sum_sat;
              end
            end
            ptp_pkg::CMD_START: begin
              a_we    = 1'b1;
              dir_nxt = dir_new;
            end
            ptp_pkg::CMD_UPDATE: begin
              w_we = 1'b1;
            end
            default: ;  // unused code: no effect
          endcase
        end
      end
      default: state_nxt = ptp_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      sum_r       <= '0;
      dir_r       <= ptp_pkg::DIR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      sum_r       <= sum_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pred_r <= out_pred_nxt;
    if (in_acc) begin
      cmd_r  <= ptp_pkg::cmd_t'(in_cmd);
      slot_r <= w_raddr;
      key_r  <= in_task_key;
      miss_r <= in_miss_count;
      last_r <= in_last_feature;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_acc_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ptp_pkg::ST_EXEC)
    else $error("accepted request did not enter execute");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ptp_pkg::ST_IDLE |-> !w_we && !a_we)
    else $error("memory write while idle");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r >= ptp_pkg::PRED_BITS'(ptp_pkg::SUM_MIN)
    && sum_r <= ptp_pkg::PRED_BITS'(ptp_pkg::SUM_MAX))
    else $error("running sum out of range");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ptp_pkg::ST_EXEC
                                 && cmd_r == ptp_pkg::CMD_CHECK && last_r))
    else $error("result without a final check");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_pred_r))
    else $error("waiting result overwritten");

endmodule

// File: hw/rtl/ptp_ram.sv
module ptp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: verif/perceptron_task_predictor_test.sv
`timescale 1ns / 1ps

module perceptron_task_predictor_test;

  // cmd 3 has no meaning; the block must drop it silently
  localparam logic [ptp_pkg::CMD_BITS-1:0]      CMD_UNUSED = 2'd3;
  // rank_xor is register 0
  localparam logic [ptp_pkg::APB_ADDR_BITS-1:0] RANK_ADDR  = '0;
  // longest run of cycles with no handshake at all; it must outlast the
  // post-reset clear sweep
  localparam int WATCHDOG_LIMIT = 5000;
  // requests that give no prediction can still be held in the block
  // when the last prediction lands
  localparam int SETTLE_CYCLES  = 8;
  localparam int POOL_SIZE      = 6;

  typedef struct packed {
    logic [ptp_pkg::CMD_BITS-1:0]   cmd;
    logic [ptp_pkg::INDEX_BITS-1:0] feature;
    logic [ptp_pkg::TASK_BITS-1:0]  key;
    logic [ptp_pkg::MISS_BITS-1:0]  misses;
    logic                           last;
  } req_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic [ptp_pkg::CMD_BITS-1:0]          in_cmd = '0;
  logic [ptp_pkg::INDEX_BITS-1:0]        in_feature_index = '0;
  logic [ptp_pkg::TASK_BITS-1:0]         in_task_key = '0;
  logic [ptp_pkg::MISS_BITS-1:0]         in_miss_count = '0;
  logic                                  in_last_feature = 1'b0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [ptp_pkg::PRED_BITS-1:0]  out_prediction;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [ptp_pkg::APB_ADDR_BITS-1:0]     paddr = '0;
  logic [ptp_pkg::APB_DATA_BITS-1:0]     pwdata = '0;
  logic [ptp_pkg::APB_DATA_BITS-1:0]     prdata;
  logic                                  pready;

  perceptron_task_predictor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_feature_index (in_feature_index),
    .in_task_key      (in_task_key),
    .in_miss_count    (in_miss_count),
    .in_last_feature  (in_last_feature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prediction   (out_prediction),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the predictor state, advanced once per accepted request
  // ---------------------------------------------------------------------
  logic signed [ptp_pkg::WEIGHT_BITS-1:0] weight_sh [ptp_pkg::W_DEPTH];
  logic [ptp_pkg::MISS_BITS-1:0]          avg_sh    [ptp_pkg::A_DEPTH];
  logic signed [ptp_pkg::PRED_BITS-1:0]   sum_sh = '0;
  ptp_pkg::dir_t                          dir_sh = ptp_pkg::DIR_NONE;
  logic [ptp_pkg::INDEX_BITS-1:0]         rank_sh = '0;

  // Stimulus side keeps its own view of the averages so that it can aim
  // miss counts above or below them
  logic [ptp_pkg::MISS_BITS-1:0]          plan_avg  [ptp_pkg::A_DEPTH];
  logic [ptp_pkg::INDEX_BITS-1:0]         pool_slot [POOL_SIZE];

  req_t                                   request_q[$];
  logic signed [ptp_pkg::PRED_BITS-1:0]   pending_predictions[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  req_took = 1'b0;

  initial begin
    for (int i = 0; i < ptp_pkg::W_DEPTH; i++) weight_sh[i] = '0;
    for (int i = 0; i < ptp_pkg::A_DEPTH; i++) begin
      avg_sh[i]   = '0;
      plan_avg[i] = '0;
    end
  end

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Applies one request to the shadow state. Returns 1 and the prediction
  // when the request is the last check feature of a task.
  function automatic bit predict_request(input req_t r,
                                         output logic signed [ptp_pkg::PRED_BITS-1:0] pred);
    logic [ptp_pkg::INDEX_BITS-1:0] slot;
    logic [ptp_pkg::MISS_BITS-1:0]  avg;
    logic [ptp_pkg::MISS_BITS:0]    total;
    int                             s;
    int                             w;
    slot = r.feature ^ rank_sh;
    pred = '0;
    predict_request = 1'b0;
    case (r.cmd)
      ptp_pkg::CMD_CHECK: begin
        // running sum saturates after every addition
        s = int'(sum_sh) + int'(weight_sh[slot]);
        if (s < ptp_pkg::SUM_MIN) s = ptp_pkg::SUM_MIN;
        if (s > ptp_pkg::SUM_MAX) s = ptp_pkg::SUM_MAX;
        if (r.last) begin
          pred = s[ptp_pkg::PRED_BITS-1:0];
          sum_sh = '0;
          predict_request = 1'b1;
        end else begin
          sum_sh = s[ptp_pkg::PRED_BITS-1:0];
        end
      end
      ptp_pkg::CMD_START: begin
        avg = avg_sh[r.key];
        if (avg == '0) begin
          // first sample for this key: store it, freeze the weights
          avg_sh[r.key] = r.misses;
          dir_sh = ptp_pkg::DIR_NONE;
        end else begin
          // 33-bit sum so the halving cannot overflow
          total = {1'b0, avg} + {1'b0, r.misses};
          avg_sh[r.key] = total[ptp_pkg::MISS_BITS:1];
          if (r.misses > avg)      dir_sh = ptp_pkg::DIR_DOWN;
          else if (r.misses < avg) dir_sh = ptp_pkg::DIR_UP;
          else                     dir_sh = ptp_pkg::DIR_NONE;
        end
      end
      ptp_pkg::CMD_UPDATE: begin
        w = int'(weight_sh[slot]);
        if (dir_sh == ptp_pkg::DIR_DOWN)    w--;
        else if (dir_sh == ptp_pkg::DIR_UP) w++;
        if (w < ptp_pkg::WEIGHT_MIN) w = ptp_pkg::WEIGHT_MIN;
        if (w > ptp_pkg::WEIGHT_MAX) w = ptp_pkg::WEIGHT_MAX;
        weight_sh[slot] = w[ptp_pkg::WEIGHT_BITS-1:0];
      end
      default: ;  // unused command: no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: new request at the falling edge once the previous one is taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_took) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_valid         <= 1'b1;
        in_cmd           <= nxt.cmd;
        in_feature_index <= nxt.feature;
        in_task_key      <= nxt.key;
        in_miss_count    <= nxt.misses;
        in_last_feature  <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: request side first so a prediction is queued before any
  // result is checked in the same edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    req_t                                 r;
    logic signed [ptp_pkg::PRED_BITS-1:0] pred;
    logic signed [ptp_pkg::PRED_BITS-1:0] want;
    req_took = rst_n && in_valid && !in_stall;
    if (req_took) begin
      r = '{in_cmd, in_feature_index, in_task_key, in_miss_count, in_last_feature};
      if (predict_request(r, pred)) pending_predictions.push_back(pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_predictions.size() == 0) begin
        flag_error($sformatf("unexpected prediction %0d", out_prediction));
      end else begin
        want = pending_predictions.pop_front();
        if (out_prediction !== want)
          flag_error($sformatf("prediction mismatch: expected %0d, got %0d",
                               want, out_prediction));
      end
    end
  end

  // Watchdog: any handshake on any port resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Queues one request; returns 1 unless it is a command the block ignores
  function automatic int push_req(input logic [ptp_pkg::CMD_BITS-1:0] cmd,
                                  input logic [ptp_pkg::INDEX_BITS-1:0] feature,
                                  input logic [ptp_pkg::TASK_BITS-1:0] key,
                                  input logic [ptp_pkg::MISS_BITS-1:0] misses,
                                  input logic last);
    logic [ptp_pkg::MISS_BITS:0] total;
    request_q.push_back('{cmd, feature, key, misses, last});
    if (cmd == ptp_pkg::CMD_START) begin
      if (plan_avg[key] == '0) begin
        plan_avg[key] = misses;
      end else begin
        total = {1'b0, plan_avg[key]} + {1'b0, misses};
        plan_avg[key] = total[ptp_pkg::MISS_BITS:1];
      end
    end
    return (cmd == CMD_UNUSED) ? 0 : 1;
  endfunction

  // Mostly a small fixed set of weight slots, so weights pile up to the
  // saturation limits; the XOR keeps the same slots across rank changes
  function automatic logic [ptp_pkg::INDEX_BITS-1:0] pick_feature();
    if ($urandom_range(99) < 85)
      return pool_slot[$urandom_range(POOL_SIZE-1)] ^ rank_sh;
    return ptp_pkg::INDEX_BITS'($urandom);
  endfunction

  // Waits until every request is taken and every prediction has arrived
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || pending_predictions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes rank_xor, then reads it back
  task automatic set_rank(input logic [ptp_pkg::INDEX_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RANK_ADDR;
    pwdata  <= ptp_pkg::APB_DATA_BITS'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rank_sh = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ptp_pkg::APB_DATA_BITS'(value))
      flag_error($sformatf("rank_xor read-back: expected %0h, got %0h", value, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: mostly whole tasks (checks ending in a last feature,
  // an update start aimed at a direction, then a run of update features),
  // plus noise and torn sequences
  task automatic run_random(input int count);
    int                             made;
    int                             tasks;
    int                             kind;
    int                             len;
    ptp_pkg::dir_t                  trend;
    ptp_pkg::dir_t                  aim;
    logic [ptp_pkg::TASK_BITS-1:0]  key;
    logic [ptp_pkg::MISS_BITS-1:0]  avg;
    logic [ptp_pkg::MISS_BITS-1:0]  miss;
    made  = 0;
    tasks = 0;
    trend = ptp_pkg::DIR_UP;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        // noise over the full range of every field, unused command too
        made += push_req(ptp_pkg::CMD_BITS'($urandom_range(3)),
                         ptp_pkg::INDEX_BITS'($urandom),
                         ptp_pkg::TASK_BITS'($urandom), $urandom,
                         1'($urandom_range(1)));
      end else if (kind < 22) begin
        if ($urandom_range(1)) begin
          // updates with no fresh start: stale direction applies
          len = $urandom_range(4, 1);
          for (int i = 0; i < len; i++)
            made += push_req(ptp_pkg::CMD_UPDATE, pick_feature(),
                             ptp_pkg::TASK_BITS'($urandom), $urandom, 1'b0);
        end else begin
          // checks without a last feature: sum carries into the next task
          len = $urandom_range(5, 1);
          for (int i = 0; i < len; i++)
            made += push_req(ptp_pkg::CMD_CHECK, pick_feature(),
                             ptp_pkg::TASK_BITS'($urandom), $urandom, 1'b0);
        end
      end else begin
        tasks++;
        // long runs in one direction drive weights into saturation
        if (tasks % 10 == 0)
          trend = (trend == ptp_pkg::DIR_UP) ? ptp_pkg::DIR_DOWN : ptp_pkg::DIR_UP;
        len = $urandom_range(20, 1);
        for (int i = 0; i < len; i++)
          made += push_req(ptp_pkg::CMD_CHECK, pick_feature(),
                           ptp_pkg::TASK_BITS'($urandom), $urandom, i == len - 1);
        key  = ($urandom_range(9) == 0) ? ptp_pkg::TASK_BITS'($urandom)
                                        : ptp_pkg::TASK_BITS'($urandom_range(3));
        avg  = plan_avg[key];
        aim  = ($urandom_range(4) != 0) ? trend : ptp_pkg::dir_t'($urandom_range(2));
        case (aim)
          ptp_pkg::DIR_UP:
            miss = (avg == '0) ? ptp_pkg::MISS_BITS'($urandom) : $urandom_range(avg - 1);
          ptp_pkg::DIR_DOWN:
            miss = (avg == '1) ? avg : avg + 1 + $urandom_range(~avg - 1);
          default:  miss = avg;
        endcase
        made += push_req(ptp_pkg::CMD_START, ptp_pkg::INDEX_BITS'($urandom), key, miss,
                         1'($urandom_range(1)));
        len = $urandom_range(14, 4);
        for (int i = 0; i < len; i++)
          made += push_req(ptp_pkg::CMD_UPDATE, pick_feature(),
                           ptp_pkg::TASK_BITS'($urandom), $urandom,
                           1'($urandom_range(1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : sequence_main
    int unused;
    for (int i = 0; i < POOL_SIZE; i++) pool_slot[i] = ptp_pkg::INDEX_BITS'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register write lands during the clear sweep
    set_rank('0);

    send_idle_pct = 37;
    recv_idle_pct = 49;
    // directed: empty-table checks, zero average, first sample, up / down /
    // equal steps, no-overflow averaging at the top of the range, unused cmd
    unused = push_req(ptp_pkg::CMD_CHECK,  '0,       '0,  '0,       1'b1);
    unused = push_req(ptp_pkg::CMD_CHECK,  '1,       '1,  '1,       1'b0);
    unused = push_req(ptp_pkg::CMD_CHECK,  '0,       '0,  '0,       1'b1);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '0,  32'd100,  1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '0,  32'd50,   1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, '1,       '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_CHECK,  10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_CHECK,  '1,       '0,  '0,       1'b1);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '0,  '1,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '1,  '1,       1'b0);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '1,  '1,       1'b0);
    unused = push_req(ptp_pkg::CMD_UPDATE, 10'd5,    '0,  '0,       1'b0);
    unused = push_req(ptp_pkg::CMD_START,  '0,       '1,  '0,       1'b0);
    unused = push_req(CMD_UNUSED,          '1,       '1,  '1,       1'b1);
    unused = push_req(ptp_pkg::CMD_CHECK,  10'd5,    '0,  '0,       1'b1);
    wait_idle();

    // sender idles less than the receiver
    set_rank('1);
    run_random(176);
    wait_idle();

    // receiver idles less than the sender
    set_rank(ptp_pkg::INDEX_BITS'($urandom));
    send_idle_pct = 49;
    recv_idle_pct = 37;
    run_random(176);
    wait_idle();

    // full throughput
    set_rank(ptp_pkg::INDEX_BITS'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(176);
    wait_idle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ptp_pkg.sv
hw/rtl/ptp_ram.sv
hw/rtl/perceptron_task_predictor.sv
verif/perceptron_task_predictor_test.sv
